// ----- rtl/hsk_pkg.sv -----
package hsk_pkg;

  localparam int CODE_W            = 8;
  localparam int SLOT_OUTPUTS      = 6;
  localparam int REPORT_SLOTS_DEF  = 6;
  localparam int PRESSED_DEPTH_DEF = 16;
  localparam int FN_PAIRS_DEF      = 4;
  localparam int FN_PAIRS_MAX      = 4;
  localparam int CFG_W             = 32;
  localparam int ADDR_W            = 3;

  localparam logic [1:0] KIND_ORDINARY = 2'd0;
  localparam logic [1:0] KIND_FN       = 2'd1;
  localparam logic [1:0] KIND_MODIFIER = 2'd2;

  localparam logic [2:0] MOD_SHIFT     = 3'd0;
  localparam logic [2:0] MOD_CTRL      = 3'd1;
  localparam logic [2:0] MOD_ALT       = 3'd2;
  localparam logic [2:0] MOD_GUI       = 3'd3;
  localparam logic [2:0] MOD_RIGHT_ALT = 3'd4;

  localparam logic REG_FN_SOURCE = 1'b0;
  localparam logic REG_FN_TARGET = 1'b1;

  localparam logic [CFG_W-1:0] FN_SOURCE_RESET = 32'd252382478;
  localparam logic [CFG_W-1:0] FN_TARGET_RESET = 32'd1330664786;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [SLOT_OUTPUTS-1:0] slot_arr_t;

  typedef struct packed {
    logic [CFG_W-1:0] src;
    logic [CFG_W-1:0] tgt;
  } fn_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_FILL,
    ST_CHECK,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  function automatic code_t modifier_mask(input logic [2:0] which);
    code_t m;
    case (which)
      MOD_SHIFT:     m = 8'h02;
      MOD_CTRL:      m = 8'h01;
      MOD_ALT:       m = 8'h04;
      MOD_GUI:       m = 8'h08;
      MOD_RIGHT_ALT: m = 8'h40;
      default:       m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/hid_six_key_report_builder_unit.sv -----
// Channel   Handshake            Payload
// in        in_valid/in_ready    key_valid key_kind key_code modifier_which frame_end
// out       out_valid/out_ready  report_slot_0..report_slot_5 modifier_byte
// cfg       APB psel/penable     paddr pwdata prdata (pready tied high)
//
// Words without frame_end are taken back to back while idle. A frame-end word then holds
// in_ready low while the block walks the pressed list twice through the shared
// map-and-compare unit (gather, then check), fills one slot a cycle between the two
// walks, clears the slots left unheld and emits.
// Reset (rst, synchronous) clears slots, count, modifiers and FN flag.
// A report still waiting on out_ready holds emit; in_ready stays low meanwhile.
module hid_six_key_report_builder_unit #(
  parameter int REPORT_SLOTS  = hsk_pkg::REPORT_SLOTS_DEF,
  parameter int PRESSED_DEPTH = hsk_pkg::PRESSED_DEPTH_DEF,
  parameter int FN_PAIRS      = hsk_pkg::FN_PAIRS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       key_valid,
  input  logic [1:0]                 key_kind,
  input  logic [7:0]                 key_code,
  input  logic [2:0]                 modifier_which,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 report_slot_0,
  output logic [7:0]                 report_slot_1,
  output logic [7:0]                 report_slot_2,
  output logic [7:0]                 report_slot_3,
  output logic [7:0]                 report_slot_4,
  output logic [7:0]                 report_slot_5,
  output logic [7:0]                 modifier_byte,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hsk_pkg::ADDR_W-1:0] paddr,
  input  logic [hsk_pkg::CFG_W-1:0]  pwdata,
  output logic [hsk_pkg::CFG_W-1:0]  prdata,
  output logic                       pready
);
  import hsk_pkg::*;

  localparam int CW  = $clog2(PRESSED_DEPTH + 1);
  localparam int IW  = (PRESSED_DEPTH > 1) ? $clog2(PRESSED_DEPTH) : 1;
  localparam int SIW = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
  localparam int JW  = $clog2(REPORT_SLOTS + 1);

  fn_cfg_t cfg;

  state_t state, state_next;

  code_t     list_mem [PRESSED_DEPTH];
  code_t     mem_q;
  logic      rd_pend;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] count;

  slot_arr_t slots;
  code_t     fresh [REPORT_SLOTS];
  logic [JW-1:0]  fresh_cnt;
  logic [JW-1:0]  fill_used;
  logic [SIW-1:0] fill_idx;
  logic [SLOT_OUTPUTS-1:0] held;
  code_t     mod_accum;
  logic      fn_held;

  slot_arr_t out_slots;
  code_t     out_mod;

  code_t mcode;
  logic [SLOT_OUTPUTS-1:0] mhit;

  logic accept, push_key, walk_done, issue, emit;

  hsk_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hsk_match #(
    .REPORT_SLOTS (REPORT_SLOTS),
    .FN_PAIRS     (FN_PAIRS)
  ) u_match (
    .code_raw  (mem_q),
    .fn_active (fn_held),
    .cfg       (cfg),
    .slots     (slots),
    .code      (mcode),
    .hit       (mhit)
  );

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign push_key  = accept & key_valid & (key_kind == KIND_ORDINARY) &
                     (key_code != '0) & (count < CW'(PRESSED_DEPTH));
  assign issue     = ((state == ST_GATHER) || (state == ST_CHECK)) && (rd_idx < count);
  assign walk_done = (rd_idx == count) && !rd_pend;
  assign emit      = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (push_key) begin
      list_mem[count[IW-1:0]] <= key_code;
    end
    if (issue) begin
      mem_q <= list_mem[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && frame_end) state_next = ST_GATHER;
      end
      ST_GATHER: begin
        if (walk_done) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (fill_idx == SIW'(REPORT_SLOTS - 1)) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (walk_done) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      slots     <= '0;
      mod_accum <= '0;
      fn_held   <= 1'b0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      fresh_cnt <= '0;
      fill_used <= '0;
      fill_idx  <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (push_key) begin
            count <= count + 1'b1;
          end
          if (accept && key_valid && (key_kind == KIND_FN)) begin
            fn_held <= 1'b1;
          end
          if (accept && key_valid && (key_kind == KIND_MODIFIER)) begin
            mod_accum <= mod_accum | modifier_mask(modifier_which);
          end
          rd_idx    <= '0;
          fresh_cnt <= '0;
        end
        ST_GATHER: begin
          if (rd_pend && (mhit == '0) && (fresh_cnt != JW'(REPORT_SLOTS))) begin
            fresh_cnt <= fresh_cnt + 1'b1;
          end
          fill_idx  <= '0;
          fill_used <= '0;
        end
        ST_FILL: begin
          if ((slots[fill_idx] == '0) && (fill_used < fresh_cnt)) begin
            slots[fill_idx] <= fresh[fill_used[SIW-1:0]];
            fill_used       <= fill_used + 1'b1;
          end
          fill_idx <= fill_idx + 1'b1;
          rd_idx   <= '0;
          held     <= '0;
        end
        ST_CHECK: begin
          if (rd_pend) begin
            held <= held | mhit;
          end
        end
        ST_CLEAR: begin
          for (int k = 0; k < SLOT_OUTPUTS; k++) begin
            if (!held[k]) slots[k] <= '0;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid <= 1'b1;
            count     <= '0;
            mod_accum <= '0;
            fn_held   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // newest unmatched code at the head; only the last REPORT_SLOTS are needed
  always_ff @(posedge clk) begin
    if ((state == ST_GATHER) && rd_pend && (mhit == '0)) begin
      fresh[0] <= mcode;
      for (int k = 1; k < REPORT_SLOTS; k++) begin
        fresh[k] <= fresh[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slots <= slots;
      out_mod   <= mod_accum;
    end
  end

  assign report_slot_0 = out_slots[0];
  assign report_slot_1 = out_slots[1];
  assign report_slot_2 = out_slots[2];
  assign report_slot_3 = out_slots[3];
  assign report_slot_4 = out_slots[4];
  assign report_slot_5 = out_slots[5];
  assign modifier_byte = out_mod;

endmodule

// ----- rtl/hsk_apb_regs.sv -----
module hsk_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hsk_pkg::ADDR_W-1:0] paddr,
  input  logic [hsk_pkg::CFG_W-1:0]  pwdata,
  output logic [hsk_pkg::CFG_W-1:0]  prdata,
  output logic                       pready,
  output hsk_pkg::fn_cfg_t           cfg
);
  import hsk_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src <= FN_SOURCE_RESET;
      cfg.tgt <= FN_TARGET_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_FN_SOURCE) begin
        cfg.src <= pwdata;
      end else begin
        cfg.tgt <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_FN_SOURCE) ? cfg.src : cfg.tgt;

endmodule

// ----- rtl/hsk_match.sv -----
module hsk_match #(
  parameter int REPORT_SLOTS = hsk_pkg::REPORT_SLOTS_DEF,
  parameter int FN_PAIRS     = hsk_pkg::FN_PAIRS_DEF
) (
  input  hsk_pkg::code_t                    code_raw,
  input  logic                              fn_active,
  input  hsk_pkg::fn_cfg_t                  cfg,
  input  hsk_pkg::slot_arr_t                slots,
  output hsk_pkg::code_t                    code,
  output logic [hsk_pkg::SLOT_OUTPUTS-1:0]  hit
);
  import hsk_pkg::*;

  code_t mapped;

  always_comb begin
    mapped = code_raw;
    for (int i = FN_PAIRS - 1; i >= 0; i--) begin
      if (cfg.src[CODE_W*i +: CODE_W] == code_raw) begin
        mapped = cfg.tgt[CODE_W*i +: CODE_W];
      end
    end
  end

  assign code = fn_active ? mapped : code_raw;

  always_comb begin
    for (int k = 0; k < SLOT_OUTPUTS; k++) begin
      hit[k] = (k < REPORT_SLOTS) && (slots[k] == code);
    end
  end

endmodule

// ----- verif/hid_six_key_report_builder_unit_tb.sv -----
module hid_six_key_report_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsk_pkg::*;

  localparam int HANG_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 2 * PRESSED_DEPTH_DEF + REPORT_SLOTS_DEF + 16;
  localparam int WORD_TARGET   = 450;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] MOD_UNUSED  = 3'd7;

  typedef struct packed {
    logic       key_valid;
    logic [1:0] kind;
    code_t      code;
    logic [2:0] which;
    logic       frame_end;
  } key_word_t;

  typedef struct packed {
    slot_arr_t slots;
    code_t     mods;
  } report_t;

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic             key_valid      = 1'b0;
  logic [1:0]       key_kind       = KIND_ORDINARY;
  logic [7:0]       key_code       = 8'h00;
  logic [2:0]       modifier_which = MOD_SHIFT;
  logic             frame_end      = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [7:0]       report_slot_0, report_slot_1, report_slot_2;
  logic [7:0]       report_slot_3, report_slot_4, report_slot_5;
  logic [7:0]       modifier_byte;
  logic             psel           = 1'b0;
  logic             penable        = 1'b0;
  logic             pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [CFG_W-1:0] pwdata         = '0;
  logic [CFG_W-1:0] prdata;
  logic             pready;

  // frame accumulators and report slots as the block should hold them
  code_t            held_list [PRESSED_DEPTH_DEF];
  int               held_count  = 0;
  slot_arr_t        slot_codes  = '0;
  code_t            mod_acc     = '0;
  bit               fn_flag     = 1'b0;
  logic [CFG_W-1:0] map_src     = FN_SOURCE_RESET;
  logic [CFG_W-1:0] map_tgt     = FN_TARGET_RESET;
  report_t          pending_reports [$];

  code_t held_keys [6] = '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
  bit    steady        = 1'b0;
  int    quiet_cycles  = 0;
  int    failures      = 0;
  int    words_sent    = 0;
  int    frames_closed = 0;
  int    reports_seen  = 0;
  int    reg_writes    = 0;

  hid_six_key_report_builder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .key_valid(key_valid), .key_kind(key_kind), .key_code(key_code),
    .modifier_which(modifier_which), .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .report_slot_0(report_slot_0), .report_slot_1(report_slot_1),
    .report_slot_2(report_slot_2), .report_slot_3(report_slot_3),
    .report_slot_4(report_slot_4), .report_slot_5(report_slot_5),
    .modifier_byte(modifier_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void log_failure(input string what);
    failures++;
    if (failures <= 10) $display("%s", what);
  endfunction

  function automatic code_t modifier_bit(input logic [2:0] which);
    case (which)
      MOD_CTRL:      return 8'h01;
      MOD_SHIFT:     return 8'h02;
      MOD_ALT:       return 8'h04;
      MOD_GUI:       return 8'h08;
      MOD_RIGHT_ALT: return 8'h40;
      default:       return 8'h00;
    endcase
  endfunction

  function automatic void close_frame();
    code_t   fresh [$];
    report_t r;
    bit      hit;
    if (fn_flag) begin
      for (int i = 0; i < held_count; i++) begin
        hit = 1'b0;
        for (int p = 0; p < FN_PAIRS_DEF; p++) begin
          if (!hit && held_list[i] == map_src[8*p +: 8]) begin
            held_list[i] = map_tgt[8*p +: 8];
            hit = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < held_count; i++) begin
      hit = 1'b0;
      for (int s = 0; s < REPORT_SLOTS_DEF; s++)
        if (held_list[i] == slot_codes[s]) hit = 1'b1;
      if (!hit) fresh.push_back(held_list[i]);
    end
    for (int s = 0; s < REPORT_SLOTS_DEF; s++)
      if (slot_codes[s] == 8'h00 && fresh.size() != 0) slot_codes[s] = fresh.pop_back();
    for (int s = 0; s < REPORT_SLOTS_DEF; s++) begin
      hit = 1'b0;
      for (int n = 0; n < held_count; n++)
        if (slot_codes[s] == held_list[n]) hit = 1'b1;
      if (!hit) slot_codes[s] = 8'h00;
    end
    r.slots = '0;
    for (int s = 0; s < REPORT_SLOTS_DEF; s++) r.slots[s] = slot_codes[s];
    r.mods = mod_acc;
    pending_reports.push_back(r);
    frames_closed++;
    held_count = 0;
    mod_acc    = '0;
    fn_flag    = 1'b0;
  endfunction

  function automatic void apply_key_word(input key_word_t w);
    if (w.key_valid) begin
      case (w.kind)
        KIND_ORDINARY: begin
          if (w.code != 8'h00 && held_count < PRESSED_DEPTH_DEF) begin
            held_list[held_count] = w.code;
            held_count++;
          end
        end
        KIND_FN:       fn_flag = 1'b1;
        KIND_MODIFIER: mod_acc = mod_acc | modifier_bit(w.which);
        default: ;
      endcase
    end
    if (w.frame_end) close_frame();
  endfunction

  function automatic key_word_t key_word(input logic v, input logic [1:0] k, input code_t c,
                                         input logic [2:0] m, input logic e);
    key_word_t w;
    w.key_valid = v;
    w.kind      = k;
    w.code      = c;
    w.which     = m;
    w.frame_end = e;
    return w;
  endfunction

  task automatic send_word(input key_word_t w);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 22) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    key_valid      <= w.key_valid;
    key_kind       <= w.kind;
    key_code       <= w.code;
    modifier_which <= w.which;
    frame_end      <= w.frame_end;
    do @(posedge clk); while (!in_ready);
    apply_key_word(w);
    words_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_reg(input logic sel, input logic [CFG_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      log_failure($sformatf("register %0d read %h, expected %h", sel, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_FN_SOURCE) map_src = value;
    else map_tgt = value;
    reg_writes++;
    check_reg(sel, value);
  endtask

  task automatic send_random_frame(input bit with_fn);
    key_word_t w;
    int        len;
    int        pick;
    if ($urandom_range(3) == 0) held_keys[$urandom_range(5)] = code_t'($urandom_range(40, 4));
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(7);
    if (with_fn) send_word(key_word(1'b1, KIND_FN, code_t'($urandom), 3'($urandom), 1'b0));
    for (int i = 0; i <= len; i++) begin
      pick        = $urandom_range(99);
      w.key_valid = 1'b1;
      w.code      = code_t'($urandom);
      w.which     = 3'($urandom);
      w.frame_end = (i == len);
      if (pick < 60) begin
        w.kind = KIND_ORDINARY;
        case ($urandom_range(4))
          0: w.code = map_src[8*$urandom_range(3) +: 8];
          1: ;
          default: w.code = held_keys[$urandom_range(5)];
        endcase
      end else if (pick < 70) begin
        w.kind = KIND_FN;
      end else if (pick < 85) begin
        w.kind  = KIND_MODIFIER;
        w.which = 3'($urandom_range(4));
      end else begin
        w.kind      = 2'($urandom);
        w.key_valid = 1'($urandom);
      end
      if (w.frame_end && $urandom_range(4) == 0) w.key_valid = 1'b0;
      send_word(w);
    end
  endtask

  task automatic test_register_reset_values();
    check_reg(REG_FN_SOURCE, FN_SOURCE_RESET);
    check_reg(REG_FN_TARGET, FN_TARGET_RESET);
  endtask

  task automatic test_directed_frames();
    send_word(key_word(1'b1, KIND_ORDINARY, 8'hFF, MOD_SHIFT, 1'b0));
    send_word(key_word(1'b1, KIND_ORDINARY, 8'h00, MOD_CTRL, 1'b0));
    send_word(key_word(1'b1, KIND_UNUSED, 8'h2C, MOD_UNUSED, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'h00, MOD_SHIFT, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'h00, MOD_CTRL, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'h00, MOD_ALT, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'h00, MOD_GUI, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'h00, MOD_RIGHT_ALT, 1'b0));
    send_word(key_word(1'b1, KIND_MODIFIER, 8'hFF, MOD_UNUSED, 1'b0));
    send_word(key_word(1'b0, KIND_FN, 8'h55, MOD_GUI, 1'b0));
    send_word(key_word(1'b1, KIND_ORDINARY, 8'h01, MOD_SHIFT, 1'b1));
    send_word(key_word(1'b1, KIND_FN, 8'h00, MOD_SHIFT, 1'b0));
    send_word(key_word(1'b1, KIND_ORDINARY, map_src[7:0], MOD_SHIFT, 1'b0));
    send_word(key_word(1'b1, KIND_ORDINARY, map_src[31:24], MOD_SHIFT, 1'b0));
    send_word(key_word(1'b1, KIND_ORDINARY, 8'hFF, MOD_SHIFT, 1'b0));
    send_word(key_word(1'b0, KIND_ORDINARY, 8'h00, MOD_SHIFT, 1'b1));
    send_word(key_word(1'b0, KIND_MODIFIER, 8'hAA, MOD_ALT, 1'b1));
    for (int i = 0; i < 7; i++)
      send_word(key_word(1'b1, KIND_ORDINARY, code_t'(8'h10 + i), MOD_SHIFT, i == 6));
  endtask

  task automatic test_fn_remap_settings();
    logic [CFG_W-1:0] src;
    logic [CFG_W-1:0] tgt;
    code_t            b;
    for (int phase = 0; phase < 5; phase++) begin
      b = code_t'($urandom_range(40, 4));
      case (phase)
        0: begin src = '0; tgt = '1; end
        1: begin src = '1; tgt = '0; end
        2: begin src = {b, b, held_keys[1], held_keys[0]}; tgt = $urandom; end
        3: begin
          src = {held_keys[3], held_keys[2], held_keys[1], held_keys[0]};
          tgt = $urandom;
          tgt[15:8] = 8'h00;
        end
        default: begin src = FN_SOURCE_RESET; tgt = FN_TARGET_RESET; end
      endcase
      drain_reports();
      write_reg(REG_FN_SOURCE, src);
      write_reg(REG_FN_TARGET, tgt);
      repeat (8) send_random_frame($urandom_range(3) != 0);
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (12) send_random_frame($urandom_range(2) == 0);
    drain_reports();
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    while (words_sent < WORD_TARGET) send_random_frame($urandom_range(4) == 0);
  endtask

  always @(posedge clk) begin
    if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    bit      bad;
    if (!rst && out_valid && out_ready) begin
      got.slots = {report_slot_5, report_slot_4, report_slot_3,
                   report_slot_2, report_slot_1, report_slot_0};
      got.mods  = modifier_byte;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        log_failure($sformatf("report %0d unexpected: slots %h mods %h",
                              reports_seen, got.slots, got.mods));
      end else begin
        want = pending_reports.pop_front();
        bad  = (got.mods !== want.mods);
        for (int s = 0; s < SLOT_OUTPUTS; s++)
          if (got.slots[s] !== want.slots[s]) bad = 1'b1;
        if (bad)
          log_failure($sformatf("report %0d: expected slots %h mods %h, got slots %h mods %h",
                                reports_seen, want.slots, want.mods, got.slots, got.mods));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= HANG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_reset_values();
    test_directed_frames();
    test_fn_remap_settings();
    test_back_to_back();
    test_random_frames();
    drain_reports();
    $display("Sent %0d key words closing %0d frames; %0d reports checked.",
             words_sent, frames_closed, reports_seen);
    $display("Remap registers written %0d times across five settings, all read back.",
             reg_writes);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hsk_pkg.sv
rtl/hsk_apb_regs.sv
rtl/hsk_match.sv
rtl/hid_six_key_report_builder_unit.sv
verif/hid_six_key_report_builder_unit_tb.sv
